>>> design/epve_pkg.sv
// ----------------------------------------------------------------------------
// epve_pkg: shared types and constants of the encoder position estimator
//
// Payload structs of both channels, the register set, the request format
// of the shared multiplier and the fixed-point constants.
// ----------------------------------------------------------------------------
package epve_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int FRAC_BITS     = 16;

  localparam int OUT_W  = 48;  // width of every result field
  localparam int OPV_W  = 50;  // signed operand of the multiplier
  localparam int OPC_W  = 33;  // signed coefficient of the multiplier
  localparam int MAG_W  = 32;  // coefficient magnitude
  localparam int HALF_W = 25;  // operand slice per partial product
  localparam int PP_W   = HALF_W + MAG_W;
  localparam int ACC_W  = 2 * HALF_W + MAG_W;
  localparam int SH_W   = 5;

  localparam int PADDR_W = 4;

  localparam logic [31:0] CNT_MID = 32'(1) << (COUNTER_WIDTH - 1);

  // 2pi in Q3.29 and the degree scale, both as plain signed coefficients.
  localparam logic signed [OPC_W-1:0] TWO_PI_Q29 = 33'sh0C90FDAA2;
  localparam logic signed [OPC_W-1:0] DEG_SCALE  = 33'sd360;

  localparam logic [SH_W-1:0] SH_REV  = SH_W'(30 - FRAC_BITS);
  localparam logic [SH_W-1:0] SH_DEG  = SH_W'(0);
  localparam logic [SH_W-1:0] SH_ANG  = SH_W'(29);
  localparam logic [SH_W-1:0] SH_DIFF = SH_W'(16);
  localparam logic [SH_W-1:0] SH_FB   = SH_W'(30);

  localparam logic [1:0] REG_CONV = 2'd0;
  localparam logic [1:0] REG_DGAIN = 2'd1;
  localparam logic [1:0] REG_FGAIN = 2'd2;

  localparam logic func_sample = 1'b0;
  localparam logic func_clear  = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [COUNTER_WIDTH-1:0] timer_count;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] revolutions;
    logic signed [OUT_W-1:0] degrees;
    logic signed [OUT_W-1:0] radians;
    logic signed [OUT_W-1:0] rev_rate;
    logic signed [OUT_W-1:0] angular_rate;
  } result_t;

  typedef struct packed {
    logic signed [31:0] conversion_factor;
    logic signed [31:0] derivative_gain;
    logic signed [31:0] feedback_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [OPV_W-1:0] v;
    logic signed [OPC_W-1:0] c;
    logic [SH_W-1:0]         sh;
  } mul_req_t;

endpackage

>>> design/epve_regs.sv
// ----------------------------------------------------------------------------
// epve_regs: configuration register file
//
// Three signed 32-bit registers on an APB-style port at byte offsets 0, 4
// and 8 (paddr[3:2]). Offsets 12 to 15 drop writes and read as zero.
// ----------------------------------------------------------------------------
module epve_regs
  import epve_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CONV:  cfg.conversion_factor <= pwdata;
        REG_DGAIN: cfg.derivative_gain   <= pwdata;
        REG_FGAIN: cfg.feedback_gain     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CONV:  prdata = cfg.conversion_factor;
      REG_DGAIN: prdata = cfg.derivative_gain;
      REG_FGAIN: prdata = cfg.feedback_gain;
      default:   prdata = '0;
    endcase
  end

endmodule

>>> design/epve_mul_unit.sv
// ----------------------------------------------------------------------------
// epve_mul_unit: shared scaling multiplier
//
// Computes round(v * c / 2^sh) with ties away from zero, saturated to the
// 48-bit signed range. Works in sign-magnitude with one 25x32 multiplier
// used for two partial products, then an accumulate and a round state.
// ----------------------------------------------------------------------------
module epve_mul_unit
  import epve_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  mul_req_t                req,
  output logic                    done,
  output logic signed [OUT_W-1:0] res
);

  typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_ADD, M_FIN} mstate_t;

  mstate_t           state;
  logic              neg;
  logic [OPV_W-1:0]  mv;
  logic [MAG_W-1:0]  mc;
  logic [SH_W-1:0]   sh;
  logic [PP_W-1:0]   prod;
  logic [ACC_W-1:0]  acc;

  logic [OPV_W-1:0]  v_mag;
  logic [OPC_W-1:0]  c_mag;
  logic [HALF_W-1:0] mul_a;
  logic [PP_W-1:0]   pp;
  logic [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]  rb_vec;
  logic              rb;
  logic              big;
  logic [OUT_W:0]    qsum;
  logic [OUT_W:0]    lim;
  logic [OUT_W:0]    mag;

  assign v_mag = req.v[OPV_W-1] ? OPV_W'(-req.v) : OPV_W'(req.v);
  assign c_mag = req.c[OPC_W-1] ? OPC_W'(-req.c) : OPC_W'(req.c);

  assign mul_a = (state == M_LO) ? mv[HALF_W-1:0] : mv[OPV_W-1:HALF_W];
  assign pp    = {{MAG_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mc};

  // Final rounding: the bit just below the cut decides the carry.
  assign shifted = acc >> sh;
  assign rb_vec  = acc >> (sh - SH_W'(1));
  assign rb      = (sh != '0) && rb_vec[0];
  assign big     = |shifted[ACC_W-1:OUT_W];
  assign qsum    = {1'b0, shifted[OUT_W-1:0]} + {{OUT_W{1'b0}}, rb};
  assign lim     = neg ? ((OUT_W+1)'(1) << (OUT_W - 1))
                       : (((OUT_W+1)'(1) << (OUT_W - 1)) - (OUT_W+1)'(1));
  assign mag     = (big || (qsum > lim)) ? lim : qsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            neg   <= req.v[OPV_W-1] ^ req.c[OPC_W-1];
            mv    <= v_mag;
            mc    <= c_mag[MAG_W-1:0];
            sh    <= req.sh;
            state <= M_LO;
          end
        end
        M_LO: begin
          prod  <= pp;
          state <= M_HI;
        end
        M_HI: begin
          acc   <= {{(ACC_W-PP_W){1'b0}}, prod};
          prod  <= pp;
          state <= M_ADD;
        end
        M_ADD: begin
          acc   <= acc + ({{(ACC_W-PP_W){1'b0}}, prod} << HALF_W);
          state <= M_FIN;
        end
        M_FIN: begin
          res   <= neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

>>> design/encoder_position_velocity_estimator.sv
// ----------------------------------------------------------------------------
// encoder_position_velocity_estimator: encoder position and velocity
//
// Accumulates encoder counter offsets, scales them to revolutions, degrees
// and radians, and runs a bilinear low-pass derivative for the rotation
// rate, all through one shared multiplier under a step sequencer.
//
//   channel  direction  handshake                      payload
//   sample   in         sample_valid / sample_ready    sample_t
//   result   out        result_valid / result_ready    result_t
//   config   in         APB psel/penable/pwrite/pready  32-bit registers
//
// A sample makes six passes through the shared multiplier between the
// accepting idle state and the hand-off state; a clear goes straight from
// idle to hand-off. Reset (rst, synchronous) zeroes the registers, the
// position count, the previous revolution and the filter state.
// A result waits in the output register; the next sample is taken
// meanwhile and stalls only at hand-off while that register is full.
// ----------------------------------------------------------------------------
module encoder_position_velocity_estimator
  import epve_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;
  typedef enum logic [2:0] {
    STEP_REV, STEP_DEG, STEP_RAD, STEP_T0, STEP_T1, STEP_OMEGA
  } step_t;

  state_t state;
  step_t  step;
  cfg_t   cfg;

  logic signed [31:0]       count_total;
  logic signed [OUT_W-1:0]  last_rev;
  logic signed [OUT_W-1:0]  filt;
  logic signed [OUT_W-1:0]  rev_w;
  logic signed [OUT_W-1:0]  deg_w;
  logic signed [OUT_W-1:0]  rad_w;
  logic signed [OUT_W-1:0]  t0_w;
  logic signed [OUT_W-1:0]  omega_w;

  mul_req_t                 mul_req;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [OUT_W-1:0]  mul_res;
  logic signed [OUT_W:0]    rate_sum;
  logic signed [OUT_W-1:0]  rate_sat;
  logic                     accept;
  logic                     load_result;

  epve_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  epve_mul_unit u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign mul_start    = (state == S_ISSUE);
  assign load_result  = (state == S_DONE) && (!result_valid || result_ready);

  always_comb begin
    case (step)
      STEP_REV:   mul_req = '{v: OPV_W'(count_total),
                              c: OPC_W'(cfg.conversion_factor), sh: SH_REV};
      STEP_DEG:   mul_req = '{v: OPV_W'(rev_w), c: DEG_SCALE, sh: SH_DEG};
      STEP_RAD:   mul_req = '{v: OPV_W'(rev_w), c: TWO_PI_Q29, sh: SH_ANG};
      STEP_T0:    mul_req = '{v: OPV_W'(rev_w) - OPV_W'(last_rev),
                              c: OPC_W'(cfg.derivative_gain), sh: SH_DIFF};
      STEP_T1:    mul_req = '{v: OPV_W'(filt),
                              c: OPC_W'(cfg.feedback_gain), sh: SH_FB};
      STEP_OMEGA: mul_req = '{v: OPV_W'(filt), c: TWO_PI_Q29, sh: SH_ANG};
      default:    mul_req = '0;
    endcase
  end

  // The new rate is the saturated sum of the two rounded filter terms.
  assign rate_sum = (OUT_W+1)'(t0_w) + (OUT_W+1)'(mul_res);
  always_comb begin
    if (rate_sum[OUT_W] != rate_sum[OUT_W-1]) begin
      rate_sat = rate_sum[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}}
                                 : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      rate_sat = rate_sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= STEP_REV;
      result_valid <= 1'b0;
      count_total  <= '0;
      last_rev     <= '0;
      filt         <= '0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (sample.func == func_clear) begin
              count_total <= '0;
              last_rev    <= '0;
              filt        <= '0;
              rev_w       <= '0;
              deg_w       <= '0;
              rad_w       <= '0;
              omega_w     <= '0;
              state       <= S_DONE;
            end else begin
              count_total <= count_total + 32'(sample.timer_count) - CNT_MID;
              step        <= STEP_REV;
              state       <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            state <= S_ISSUE;
            case (step)
              STEP_REV: begin
                rev_w <= mul_res;
                step  <= STEP_DEG;
              end
              STEP_DEG: begin
                deg_w <= mul_res;
                step  <= STEP_RAD;
              end
              STEP_RAD: begin
                rad_w <= mul_res;
                step  <= STEP_T0;
              end
              STEP_T0: begin
                t0_w <= mul_res;
                step <= STEP_T1;
              end
              STEP_T1: begin
                filt <= rate_sat;
                step <= STEP_OMEGA;
              end
              default: begin
                omega_w  <= mul_res;
                last_rev <= rev_w;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (load_result) begin
            result.revolutions  <= rev_w;
            result.degrees      <= deg_w;
            result.radians      <= rad_w;
            result.rev_rate     <= filt;
            result.angular_rate <= omega_w;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample_ready)
    else $error("sample channel still ready after a transfer");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_WAIT)
    else $error("multiplier finished while the sequencer was not waiting");

  a_clear_zeroes_state: assert property (@(posedge clk) disable iff (rst)
    accept && sample.func == func_clear |=> count_total == '0 && filt == '0
      && last_rev == '0)
    else $error("clear left estimator state nonzero");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the hand-off state");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the encoder position and velocity estimator
//
// Drives encoder samples and clear commands through the sample channel,
// sets the three gain registers over APB between phases, and checks every
// result against a bit-exact fixed-point position and rate predictor (or a
// literal zero in marked rows). A short directed table covers zero, unity
// and extreme gains; random phases with drifting counts then push degrees
// and rates into saturation, under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import epve_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;  // beyond the register list
  localparam logic signed [31:0] GAIN_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] GAIN_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q30_ONE  = 32'sh4000_0000;
  localparam logic signed [31:0] Q16_ONE  = 32'sh0001_0000;
  localparam logic signed [63:0] OUT_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_LO   = -OUT_HI - 64'sd1;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 158;

  typedef struct {
    logic    reload;
    cfg_t    gains;
    sample_t item;
    logic    literal;
    result_t want;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  sample_t            sample;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state and its copy of the gain registers.
  logic [31:0]        pos_count;
  logic signed [47:0] prev_rev;
  logic signed [47:0] rate_state;
  logic signed [31:0] conv_gain;
  logic signed [31:0] diff_gain;
  logic signed [31:0] fb_gain;

  result_t  motion_queue[$];
  dir_row_t dir_rows[22];
  logic     row_literal;
  result_t  row_want;
  int       send_idle;
  int       recv_idle;
  int       mismatches;
  string    field_name[5] = '{"revolutions", "degrees", "radians", "rev_rate",
                              "angular_rate"};

  encoder_position_velocity_estimator dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // round(v * c / 2^sh), ties away from zero, clamped to the 48-bit range.
  function automatic logic signed [47:0] scale_round(logic signed [63:0] v,
                                                     logic signed [63:0] c,
                                                     int sh);
    logic signed [127:0] vw, cw, prod;
    logic [127:0] mag, q;
    logic neg;
    vw = v;
    cw = c;
    prod = vw * cw;
    neg = prod < 0;
    mag = neg ? -prod : prod;
    q = (mag + (128'd1 << (sh - 1))) >> sh;
    if (!neg && q > 128'h7FFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF;
    if (neg && q > 128'h8000_0000_0000) q = 128'h8000_0000_0000;
    return neg ? 48'(-q) : 48'(q);
  endfunction

  function automatic logic signed [47:0] clamp48(logic signed [63:0] v);
    if (v > OUT_HI) return OUT_HI[47:0];
    if (v < OUT_LO) return OUT_LO[47:0];
    return v[47:0];
  endfunction

  function automatic result_t predict_motion(sample_t s);
    result_t r;
    logic signed [47:0] rev, t0, t1;
    logic signed [63:0] diff, wide;
    if (s.func == func_clear) begin
      pos_count = '0;
      prev_rev = '0;
      rate_state = '0;
      return '0;
    end
    pos_count = pos_count + 32'(s.timer_count) - CNT_MID;
    rev = scale_round($signed(pos_count), conv_gain, 30 - FRAC_BITS);
    wide = rev;
    r.revolutions = rev;
    r.degrees = clamp48(wide * 64'sd360);
    r.radians = scale_round(rev, TWO_PI_Q29, 29);
    diff = rev;
    diff = diff - prev_rev;
    t0 = scale_round(diff, diff_gain, 16);
    t1 = scale_round(rate_state, fb_gain, 30);
    wide = t0;
    rate_state = clamp48(wide + t1);
    prev_rev = rev;
    r.rev_rate = rate_state;
    r.angular_rate = scale_round(rate_state, TWO_PI_Q29, 29);
    return r;
  endfunction

  function automatic sample_t draw_sample(int clear_pct, int drift_pct, logic drift_up);
    sample_t s;
    int pick;
    s.func = func_sample;
    s.timer_count = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < clear_pct) begin
      s.func = func_clear;
    end else if (pick < clear_pct + drift_pct) begin
      s.timer_count = drift_up ? (16'hFFFF - 16'($urandom_range(15)))
                               : 16'($urandom_range(15));
    end else if (pick < clear_pct + drift_pct + 20) begin
      s.timer_count = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end else if (pick < clear_pct + drift_pct + 50) begin
      s.timer_count = 16'(32'h8000 + $urandom_range(64) - 32);
    end
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(sample_t s);
    while ($urandom_range(99) < send_idle) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = s;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid = 1'b0;
    while (motion_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CONV:  conv_gain = data;
      REG_DGAIN: diff_gain = data;
      REG_FGAIN: fb_gain = data;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_gains(cfg_t g);
    write_reg(REG_CONV, g.conversion_factor);
    write_reg(REG_DGAIN, g.derivative_gain);
    write_reg(REG_FGAIN, g.feedback_gain);
    write_reg(REG_NONE, $urandom);
  endtask

  always @(negedge clk) begin
    result_ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    logic [47:0] wv[5];
    logic [47:0] gv[5];
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        want = predict_motion(sample);
        motion_queue.push_back(row_literal ? row_want : want);
      end
      if (result_valid && result_ready) begin
        got = result;
        if (motion_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %h", got);
        end else begin
          want = motion_queue.pop_front();
          wv = '{want.revolutions, want.degrees, want.radians, want.rev_rate,
                 want.angular_rate};
          gv = '{got.revolutions, got.degrees, got.radians, got.rev_rate,
                 got.angular_rate};
          for (int f = 0; f < 5; f++) begin
            if (wv[f] !== gv[f]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", field_name[f], wv[f],
                         gv[f]);
            end
          end
        end
      end
    end
  end

  initial begin
    cfg_t gains;
    int clear_pct;
    int drift_pct;
    logic drift_up;

    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    result_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_literal = 1'b0;
    row_want = '0;
    send_idle = 32;
    recv_idle = 68;
    mismatches = 0;
    pos_count = '0;
    prev_rev = '0;
    rate_state = '0;
    conv_gain = '0;
    diff_gain = '0;
    fb_gain = '0;

    // With zero gains after reset every output is zero; a clear, or a
    // midpoint sample right after one, gives zero whatever the gains.
    dir_rows[0]  = '{1'b0, '0, '{func_sample, 16'hFFFF}, 1'b1, '0};
    dir_rows[1]  = '{1'b0, '0, '{func_sample, 16'h0000}, 1'b1, '0};
    dir_rows[2]  = '{1'b0, '0, '{func_sample, 16'h8000}, 1'b1, '0};
    dir_rows[3]  = '{1'b0, '0, '{func_clear,  16'h1234}, 1'b1, '0};
    dir_rows[4]  = '{1'b1, '{Q30_ONE, Q16_ONE, Q30_ONE}, '{func_sample, 16'h8001}, 1'b0, '0};
    dir_rows[5]  = '{1'b0, '0, '{func_sample, 16'h8001}, 1'b0, '0};
    dir_rows[6]  = '{1'b0, '0, '{func_sample, 16'h7FFF}, 1'b0, '0};
    dir_rows[7]  = '{1'b0, '0, '{func_clear,  16'hFFFF}, 1'b1, '0};
    dir_rows[8]  = '{1'b0, '0, '{func_sample, 16'h8000}, 1'b1, '0};
    dir_rows[9]  = '{1'b1, '{GAIN_MAX, GAIN_MAX, GAIN_MAX}, '{func_sample, 16'hFFFF}, 1'b0, '0};
    dir_rows[10] = '{1'b0, '0, '{func_sample, 16'hFFFF}, 1'b0, '0};
    dir_rows[11] = '{1'b0, '0, '{func_sample, 16'hFFFF}, 1'b0, '0};
    dir_rows[12] = '{1'b0, '0, '{func_sample, 16'h0000}, 1'b0, '0};
    dir_rows[13] = '{1'b0, '0, '{func_clear,  16'h0000}, 1'b1, '0};
    dir_rows[14] = '{1'b1, '{GAIN_MIN, GAIN_MIN, GAIN_MIN}, '{func_sample, 16'hFFFF}, 1'b0, '0};
    dir_rows[15] = '{1'b0, '0, '{func_sample, 16'h0000}, 1'b0, '0};
    dir_rows[16] = '{1'b0, '0, '{func_sample, 16'h0000}, 1'b0, '0};
    dir_rows[17] = '{1'b0, '0, '{func_sample, 16'h5555}, 1'b0, '0};
    dir_rows[18] = '{1'b0, '0, '{func_sample, 16'hAAAA}, 1'b0, '0};
    dir_rows[19] = '{1'b0, '0, '{func_clear,  16'h5555}, 1'b1, '0};
    dir_rows[20] = '{1'b1, '{-32'sd1, 32'sd1, -32'sd1}, '{func_sample, 16'h0001}, 1'b0, '0};
    dir_rows[21] = '{1'b0, '0, '{func_sample, 16'hFFFE}, 1'b0, '0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reload) begin
        wait_idle();
        write_gains(dir_rows[i].gains);
      end
      row_literal = dir_rows[i].literal;
      row_want = dir_rows[i].want;
      send_item(dir_rows[i].item);
    end
    row_literal = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      gains.conversion_factor = $urandom;
      gains.derivative_gain = $urandom;
      gains.feedback_gain = $urandom;
      clear_pct = 3;
      drift_pct = 20;
      drift_up = 1'($urandom_range(1));
      case (ph)
        0: gains = '{GAIN_MAX, GAIN_MAX, GAIN_MAX};
        1: gains = '{GAIN_MIN, GAIN_MIN, GAIN_MIN};
        2: begin
          // Long upward drift at full scale drives degrees into saturation.
          gains.conversion_factor = GAIN_MAX;
          clear_pct = 0;
          drift_pct = 70;
          drift_up = 1'b1;
        end
        3: begin
          clear_pct = 5;
          drift_pct = 10;
        end
        4: begin
          gains = '{GAIN_MIN, GAIN_MAX, 32'sh3F00_0000};
          clear_pct = 0;
          drift_pct = 70;
          drift_up = 1'b0;
        end
        default: ;
      endcase
      send_idle = (ph < 2) ? 32 : (ph < 4) ? 68 : 0;
      recv_idle = (ph < 2) ? 68 : (ph < 4) ? 32 : 0;
      // Every expected result drains here before the gains change.
      wait_idle();
      write_gains(gains);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(draw_sample(clear_pct, drift_pct, drift_up));
    end

    wait_idle();
    if (mismatches == 0 && motion_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/epve_pkg.sv
design/epve_regs.sv
design/epve_mul_unit.sv
design/encoder_position_velocity_estimator.sv
tb/sv/tb_top.sv
